// ===== rtl/core/ppc_pkg.sv =====
// Package for the position PID controller: widths, register file type and
// sizes of the shared multiplier and divider. No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int unsigned TIMEOUT_DEF = 4;
  localparam int unsigned CFG_AW      = 5;
  localparam int unsigned CFG_NREG    = 8;

  localparam int unsigned MUL_A_W    = 33;
  localparam int unsigned MUL_STEP_W = 16;
  localparam int unsigned MUL_STEPS  = 4;
  localparam int unsigned MUL_B_W    = MUL_STEP_W * MUL_STEPS;
  localparam int unsigned TERM_W     = 61;
  localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_DEN_W = 16;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_EXTRA_GAIN = 3'd3,
    REG_DEADBAND   = 3'd4,
    REG_DRIVE_LIM  = 3'd5,
    REG_INT_BAND   = 3'd6,
    REG_INT_LIM    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integral_gain;
    logic [31:0] deriv_gain;
    logic [31:0] extra_prop_gain;
    logic [30:0] deadband;
    logic [14:0] drive_limit;
    logic [30:0] integral_band;
    logic [30:0] integral_limit;
  } cfg_t;

endpackage

// ===== rtl/core/ppc_cfg.sv =====
// APB-style register file holding the PID gains and limits.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ppc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output ppc_pkg::cfg_t              cfg_o
);
  import ppc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= 32'd1966080;
      cfg_r.integral_gain   <= 32'd0;
      cfg_r.deriv_gain      <= 32'd0;
      cfg_r.extra_prop_gain <= 32'd1310720;
      cfg_r.deadband        <= 31'd6554;
      cfg_r.drive_limit     <= 15'd100;
      cfg_r.integral_band   <= 31'd78643;
      cfg_r.integral_limit  <= 31'd6553600;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_r.prop_gain       <= cfg_pwdata;
        REG_INT_GAIN:   cfg_r.integral_gain   <= cfg_pwdata;
        REG_DERIV_GAIN: cfg_r.deriv_gain      <= cfg_pwdata;
        REG_EXTRA_GAIN: cfg_r.extra_prop_gain <= cfg_pwdata;
        REG_DEADBAND:   cfg_r.deadband        <= cfg_pwdata[30:0];
        REG_DRIVE_LIM:  cfg_r.drive_limit     <= cfg_pwdata[14:0];
        REG_INT_BAND:   cfg_r.integral_band   <= cfg_pwdata[30:0];
        REG_INT_LIM:    cfg_r.integral_limit  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:  cfg_prdata = cfg_r.prop_gain;
      REG_INT_GAIN:   cfg_prdata = cfg_r.integral_gain;
      REG_DERIV_GAIN: cfg_prdata = cfg_r.deriv_gain;
      REG_EXTRA_GAIN: cfg_prdata = cfg_r.extra_prop_gain;
      REG_DEADBAND:   cfg_prdata = {1'b0, cfg_r.deadband};
      REG_DRIVE_LIM:  cfg_prdata = {17'd0, cfg_r.drive_limit};
      REG_INT_BAND:   cfg_prdata = {1'b0, cfg_r.integral_band};
      REG_INT_LIM:    cfg_prdata = {1'b0, cfg_r.integral_limit};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/ppc_mul.sv =====
// Shared multiplier: 16 bits of the wide operand per cycle, product capped
// at TERM_CAP. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ppc_pkg::MUL_A_W-1:0] a,
  input  logic [ppc_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [ppc_pkg::TERM_W-1:0]  p
);
  import ppc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS + 1);
  localparam int unsigned SUM_W = TERM_W + MUL_STEP_W + 1;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [TERM_W-1:0]  acc_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [MUL_A_W+MUL_STEP_W-1:0] pp;
  logic [SUM_W-1:0]   sum;

  assign pp   = a_r * b_r[MUL_B_W-1 -: MUL_STEP_W];
  assign sum  = {1'b0, acc_r, {MUL_STEP_W{1'b0}}} + SUM_W'(pp);
  assign done = done_r;
  assign p    = (ovf_r || acc_r > TERM_CAP) ? TERM_CAP : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      b_r   <= b_r << MUL_STEP_W;
      acc_r <= sum[TERM_W-1:0];
      ovf_r <= ovf_r | (|sum[SUM_W-1:TERM_W]);
    end
  end

endmodule

// ===== rtl/core/ppc_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// A zero divisor is treated as one. Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppc_pkg::DIV_NUM_W-1:0] num,
  input  logic [ppc_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [ppc_pkg::DIV_NUM_W-1:0] quot
);
  import ppc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_r, q_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= (den == '0) ? DIV_DEN_W'(1) : den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      q_r   <= {q_r[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/pid_position_controller.sv =====
// Top level of the position PID controller: sequencer, loop state, output
// register. Depends on ppc_pkg, ppc_cfg, ppc_mul and ppc_div.
`timescale 1ns / 1ps

// A set-target transaction gives no result. A control tick that runs the
// loop holds in_tready low after it is accepted, while it works through
// the error step, four passes through the shared 33x16 multiplier (each
// an issue, four partial products and done), the derivative divider
// (issue, 49 quotient steps and done), the drive step and the output
// handoff. A timed-out tick only replays the held drive. Either kind of
// tick stalls further while the previous result still waits in the output
// register. A finished result waits in the output register while the next
// transaction is taken.
module pid_position_controller #(
  parameter int unsigned TICK_LIMIT = ppc_pkg::TIMEOUT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [79:0]                in_tdata,  // target_angle, measured_angle, elapsed_time
  input  logic                       in_tuser,  // action
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata, // drive_out
  output logic                       out_tuser, // loop_active
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ppc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import ppc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_IMUL, S_IWAIT, S_DIV, S_DWAIT, S_PMUL, S_PWAIT,
    S_KIMUL, S_KIWAIT, S_KDMUL, S_KDWAIT, S_FIN, S_EMIT
  } state_t;

  cfg_t cfg;

  state_t              state_r, state_nxt;
  logic signed [31:0]  target_r, target_nxt;
  logic signed [31:0]  integ_r, integ_nxt;
  logic signed [31:0]  last_r, last_nxt;
  logic [7:0]          ticks_r, ticks_nxt;
  logic signed [15:0]  held_r, held_nxt;
  logic                act_r, act_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [15:0]         out_drive_r, out_drive_nxt;
  logic                out_act_r, out_act_nxt;

  logic signed [31:0]  meas_r, meas_nxt;
  logic [15:0]         dt_r, dt_nxt;
  logic signed [31:0]  err_r, err_nxt;
  logic                ien_r, ien_nxt;
  logic [48:0]         rate_r, rate_nxt;
  logic                rneg_r, rneg_nxt;
  logic signed [63:0]  sum_r, sum_nxt;

  logic                mul_start, mul_done;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [TERM_W-1:0]   mul_p;
  logic                div_start, div_done;
  logic [48:0]         div_q;

  logic                acc_in;
  logic signed [32:0]  raw, raw_sat;
  logic [31:0]         amag;
  logic [31:0]         err_mag, integ_mag;
  logic signed [32:0]  diff;
  logic [32:0]         diff_mag;
  logic [30:0]         inc;
  logic signed [33:0]  integ_new, lim;
  logic signed [63:0]  term_s;
  logic [63:0]         sum_mag;
  logic [31:0]         drv_hi;
  logic [14:0]         drv_mag;
  logic [7:0]          ticks_inc;

  ppc_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg_o(cfg)
  );

  ppc_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  ppc_div u_div (
    .clk, .rst_n, .start(div_start), .num({diff_mag, 16'd0}), .den(dt_r),
    .done(div_done), .quot(div_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign acc_in     = in_tvalid & in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_act_r;

  assign raw     = 33'(target_r) - 33'(meas_r);
  assign raw_sat = (raw > 33'sd2147483647) ? 33'sd2147483647 :
                   (raw < -33'sd2147483648) ? -33'sd2147483648 : raw;
  assign amag    = raw_sat[32] ? 32'(-raw_sat) : raw_sat[31:0];
  assign err_mag   = err_r[31] ? 32'(-33'(err_r)) : err_r;
  assign integ_mag = integ_r[31] ? 32'(-33'(integ_r)) : integ_r;
  assign diff      = 33'(err_r) - 33'(last_r);
  assign diff_mag  = diff[32] ? 33'(-diff) : diff;
  assign inc       = mul_p[46:16];
  assign integ_new = 34'(integ_r) + (err_r[31] ? -34'(inc) : 34'(inc));
  assign lim       = 34'(cfg.integral_limit);
  assign term_s    = 64'(mul_p);
  assign sum_mag   = sum_r[63] ? 64'(-sum_r) : sum_r;
  assign drv_hi    = sum_mag[63:32];
  assign drv_mag   = (drv_hi > 32'(cfg.drive_limit)) ? cfg.drive_limit : drv_hi[14:0];
  assign ticks_inc = ticks_r + 8'd1;

  assign div_start = (state_r == S_DIV);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IMUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(dt_r);
        mul_b     = MUL_B_W'(err_mag);
      end
      S_PMUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(cfg.prop_gain) + MUL_A_W'(cfg.extra_prop_gain);
        mul_b     = MUL_B_W'(err_mag);
      end
      S_KIMUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(cfg.integral_gain);
        mul_b     = MUL_B_W'(integ_mag);
      end
      S_KDMUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(cfg.deriv_gain);
        mul_b     = MUL_B_W'(rate_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    target_nxt     = target_r;
    integ_nxt      = integ_r;
    last_nxt       = last_r;
    ticks_nxt      = ticks_r;
    held_nxt       = held_r;
    act_nxt        = act_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_drive_nxt  = out_drive_r;
    out_act_nxt    = out_act_r;
    meas_nxt       = meas_r;
    dt_nxt         = dt_r;
    err_nxt        = err_r;
    ien_nxt        = ien_r;
    rate_nxt       = rate_r;
    rneg_nxt       = rneg_r;
    sum_nxt        = sum_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_tuser) begin
            target_nxt = in_tdata[31:0];
            ticks_nxt  = '0;
          end else if (ticks_r < 8'(TICK_LIMIT)) begin
            meas_nxt  = in_tdata[63:32];
            dt_nxt    = in_tdata[79:64];
            state_nxt = S_ERR;
          end else begin
            act_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_ERR: begin
        err_nxt   = (amag < {1'b0, cfg.deadband}) ? 32'sd0 : raw_sat[31:0];
        ien_nxt   = (amag > {1'b0, cfg.integral_band}) && (amag >= {1'b0, cfg.deadband});
        state_nxt = S_IMUL;
      end
      S_IMUL: state_nxt = S_IWAIT;
      S_IWAIT: begin
        if (mul_done) begin
          if (!ien_r) begin
            integ_nxt = '0;
          end else if (integ_new > lim) begin
            integ_nxt = 32'(lim);
          end else if (integ_new < -lim) begin
            integ_nxt = 32'(-lim);
          end else begin
            integ_nxt = integ_new[31:0];
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          rate_nxt  = div_q;
          rneg_nxt  = diff[32];
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: state_nxt = S_PWAIT;
      S_PWAIT: begin
        if (mul_done) begin
          sum_nxt   = err_r[31] ? -term_s : term_s;
          state_nxt = S_KIMUL;
        end
      end
      S_KIMUL: state_nxt = S_KIWAIT;
      S_KIWAIT: begin
        if (mul_done) begin
          sum_nxt   = integ_r[31] ? sum_r - term_s : sum_r + term_s;
          state_nxt = S_KDMUL;
        end
      end
      S_KDMUL: state_nxt = S_KDWAIT;
      S_KDWAIT: begin
        if (mul_done) begin
          sum_nxt   = rneg_r ? sum_r + term_s : sum_r - term_s;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        held_nxt  = (ticks_inc == 8'(TICK_LIMIT)) ? 16'sd0 :
                    (sum_r[63] ? -16'(drv_mag) : 16'(drv_mag));
        ticks_nxt = ticks_inc;
        last_nxt  = err_r;
        act_nxt   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_drive_nxt  = held_r;
          out_act_nxt    = act_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= '0;
      integ_r      <= '0;
      last_r       <= '0;
      ticks_r      <= '0;
      held_r       <= '0;
      act_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      target_r     <= target_nxt;
      integ_r      <= integ_nxt;
      last_r       <= last_nxt;
      ticks_r      <= ticks_nxt;
      held_r       <= held_nxt;
      act_r        <= act_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_drive_r <= out_drive_nxt;
    out_act_r   <= out_act_nxt;
    meas_r      <= meas_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    ien_r       <= ien_nxt;
    rate_r      <= rate_nxt;
    rneg_r      <= rneg_nxt;
    sum_r       <= sum_nxt;
  end

  a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_r <= 8'(TICK_LIMIT))
    else $error("tick count beyond timeout");

  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_tuser) |=> (ticks_r == 8'd0))
    else $error("set target did not restart tick count");

  a_drive_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ((out_tdata[15] ? 16'(-out_tdata) : out_tdata) <= 16'(cfg.drive_limit)))
    else $error("drive exceeds limit");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_IWAIT || state_r == S_PWAIT ||
                  state_r == S_KIWAIT || state_r == S_KDWAIT))
    else $error("multiplier finished outside a wait state");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for pid_position_controller: random and directed set-target and
// tick transactions, checked against a fixed-point loop predictor.
// Depends on ppc_pkg and the controller RTL.
`timescale 1ns / 1ps

import ppc_pkg::*;

typedef struct {
  logic [15:0] drive;
  logic        active;
} drive_result_t;

class pid_scoreboard;
  localparam longint unsigned CAP = 64'd1 << 60;
  localparam int unsigned TMO = TIMEOUT_DEF;

  drive_result_t     drive_q[$];
  int                errors;
  logic [31:0]       kp, ki, kd, km;
  logic [30:0]       dband, iband, ilim;
  logic [14:0]       dlim;
  longint            tgt, isum, last_err, held;
  int unsigned       ticks;

  function new();
    errors = 0;
    kp = 32'd1966080; ki = 0; kd = 0; km = 32'd1310720;
    dband = 31'd6554; dlim = 15'd100; iband = 31'd78643; ilim = 31'd6553600;
    tgt = 0; isum = 0; last_err = 0; held = 0; ticks = 0;
  endfunction

  function void set_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_PROP_GAIN:  kp = v;
      REG_INT_GAIN:   ki = v;
      REG_DERIV_GAIN: kd = v;
      REG_EXTRA_GAIN: km = v;
      REG_DEADBAND:   dband = v[30:0];
      REG_DRIVE_LIM:  dlim = v[14:0];
      REG_INT_BAND:   iband = v[30:0];
      REG_INT_LIM:    ilim = v[30:0];
      default: ;
    endcase
  endfunction

  function longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint capped_term(longint unsigned gain, longint v);
    longint unsigned m, p;
    m = magnitude(v);
    if (gain != 0 && m > CAP / gain) p = CAP;
    else begin
      p = gain * m;
      if (p > CAP) p = CAP;
    end
    return v < 0 ? -longint'(p) : longint'(p);
  endfunction

  function longint shift_toward_zero(longint v, int s);
    longint unsigned m;
    m = magnitude(v) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function void note_input(logic action, logic [31:0] target, logic [31:0] meas,
                           logic [15:0] dt);
    longint raw, err, lim, rate, sum, drive, dtl;
    longint unsigned amag;
    drive_result_t r;
    if (action) begin
      tgt = longint'(signed'(target));
      ticks = 0;
      return;
    end
    r.active = 0;
    if (ticks < TMO) begin
      dtl = longint'(dt);
      raw = tgt - longint'(signed'(meas));
      if (raw > 64'sd2147483647) raw = 64'sd2147483647;
      if (raw < -64'sd2147483648) raw = -64'sd2147483648;
      amag = magnitude(raw);
      err = (amag < dband) ? 0 : raw;
      if (amag > iband && amag >= dband) begin
        lim = longint'(ilim);
        isum += shift_toward_zero(err * dtl, 16);
        if (isum > lim) isum = lim;
        if (isum < -lim) isum = -lim;
      end else begin
        isum = 0;
      end
      rate = ((err - last_err) * 65536) / (dtl == 0 ? 1 : dtl);
      sum = capped_term(longint'(kp) + longint'(km), err) + capped_term(ki, isum)
          - capped_term(kd, rate);
      last_err = err;
      drive = shift_toward_zero(sum, 32);
      if (drive > longint'(dlim)) drive = longint'(dlim);
      if (drive < -longint'(dlim)) drive = -longint'(dlim);
      held = drive;
      ticks++;
      if (ticks == TMO) held = 0;
      r.active = 1;
    end
    r.drive = held[15:0];
    drive_q.push_back(r);
  endfunction

  function void check(logic [15:0] drive, logic active);
    drive_result_t e;
    if (drive_q.size() == 0) begin
      $display("%0t: unexpected result drive=%0d active=%0b", $time, signed'(drive), active);
      errors++;
      return;
    end
    e = drive_q.pop_front();
    if (drive !== e.drive) begin
      $display("%0t: drive_out expected %0d actual %0d", $time, signed'(e.drive),
               signed'(drive));
      errors++;
    end
    if (active !== e.active) begin
      $display("%0t: loop_active expected %0b actual %0b", $time, e.active, active);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid, out_tready, out_tuser;
  logic [15:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  pid_scoreboard sb;
  logic [31:0]   cur_target;

  pid_position_controller dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // result side: random backpressure, check at rising edge
  initial begin
    int unsigned stall;
    int unsigned quiet;
    stall = 0;
    quiet = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
      @(negedge clk);
      if (quiet > 0) begin
        quiet--;
        out_tready = 1;
      end else if (stall > 0) begin
        stall--;
        out_tready = 0;
      end else begin
        if ($urandom_range(0, 49) == 0) quiet = $urandom_range(50, 400);
        stall = gap_len();
        out_tready = (stall == 0);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_penable = 0;
    cfg_paddr = CFG_AW'(idx) << 2;
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
  endtask

  task automatic send_item(logic action, logic [31:0] target, logic [31:0] meas,
                           logic [15:0] dt);
    int unsigned g;
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = action;
    in_tdata = {dt, meas, target};
    do @(posedge clk); while (!in_tready);
    sb.note_input(action, target, meas, dt);
    if (action) cur_target = target;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_tvalid = 0;
      in_tdata = 80'({$urandom, $urandom, $urandom});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function logic [31:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: return cur_target + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function logic [15:0] pick_dt();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(300, 5000));
    endcase
  endfunction

  task automatic random_items(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(1'b1, pick_angle(), $urandom, 16'($urandom));
        k++;
        repeat ($urandom_range(1, 6)) begin
          send_item(1'b0, $urandom, pick_angle(), pick_dt());
          k++;
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom, $urandom, pick_dt());
        k++;
      end
    end
  endtask

  task automatic set_all(logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(REG_PROP_GAIN, v0);
    write_reg(REG_INT_GAIN, v1);
    write_reg(REG_DERIV_GAIN, v2);
    write_reg(REG_EXTRA_GAIN, v3);
    write_reg(REG_DEADBAND, v4);
    write_reg(REG_DRIVE_LIM, v5);
    write_reg(REG_INT_BAND, v6);
    write_reg(REG_INT_LIM, v7);
  endtask

  initial begin
    sb = new();
    cur_target = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: overflow, deadband, band, timeout, dt extremes
    send_item(0, 0, 32'd1000, 16'd100);
    send_item(1, 32'h7fff_ffff, 0, 0);
    send_item(0, 0, 32'h8000_0000, 16'd1);
    send_item(0, 0, 32'h7fff_ffff, 16'hffff);
    send_item(0, 0, 32'h7fff_d000, 16'd500);
    send_item(0, 0, 32'h7ffe_0000, 16'd500);
    send_item(0, 0, 32'h0, 16'd500);
    send_item(1, 32'h8000_0000, 0, 16'hffff);
    send_item(0, 0, 32'h7fff_ffff, 16'd1);
    send_item(0, 0, 32'h8000_0000, 16'hffff);
    send_item(1, 0, 0, 0);
    send_item(0, 0, 32'hfffe_7000, 16'd2000);
    send_item(0, 0, 32'h0000_1000, 16'd2000);
    send_item(0, 0, 32'h0000_0000, 16'd1);
    send_item(0, 0, 32'hffff_0000, 16'd65535);
    drain();

    set_all(32'd65536, 32'd32768, 32'd4096, 32'd65536, 32'd655, 32'd32767, 32'd65536,
            32'd655360);
    send_item(1, 32'd200000, 0, 0);
    repeat (4) send_item(0, 0, 32'hfff0_0000, 16'd3000);
    send_item(0, 0, 32'd200000, 16'd1);
    random_items(120);
    drain();

    set_all('1, '1, '1, '1, 32'h7fff_ffff, 32'h7fff, 32'h7fff_ffff, 32'h7fff_ffff);
    random_items(80);
    drain();

    set_all(0, 0, 0, 0, 0, 0, 0, 0);
    random_items(60);
    drain();

    set_all('1, '1, '1, '1, 0, 32'h7fff, 0, 32'h7fff_ffff);
    random_items(80);
    drain();

    repeat (3) begin
      set_all($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1 << 18),
              $urandom, $urandom_range(0, 1 << 20), $urandom);
      random_items(90);
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
